[hw/rtl/tlbr_pkg.sv]
// ----------------------------------------------------------------------------
// tlbr_pkg
// Shared sizes, codes and types of the translation buffer with FIFO or LRU
// replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbr_pkg;

    localparam int TLB_DEPTH  = 32;
    localparam int PID_BITS   = 16;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_BITS = 20;
    localparam int AGE_BITS   = 32;

    localparam int IDX_BITS  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int SLOT_BITS = 5;
    localparam int USE_BITS  = 6;
    localparam int DEPTH_CNT_BITS = $clog2(TLB_DEPTH + 1);
    localparam int ACT_BITS  = (USE_BITS > DEPTH_CNT_BITS) ? USE_BITS : DEPTH_CNT_BITS;
    localparam int SCAN_BITS = DEPTH_CNT_BITS;

    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // register index is byte address bit 2
    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    localparam logic [USE_BITS-1:0] USE_RESET = 6'd32;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [AGE_BITS-1:0] CLOCK_RESET = AGE_BITS'(1);

    typedef struct packed {
        logic [PID_BITS-1:0]  pid;
        logic [PAGE_BITS-1:0] page;
    } key_t;

    // partial search result walking down the row of cells
    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   hit_idx;
        logic [FRAME_BITS-1:0] frame;
        logic                  empty;
        logic [IDX_BITS-1:0]   empty_idx;
        logic [AGE_BITS-1:0]   min_age;
        logic [IDX_BITS-1:0]   min_idx;
    } carry_t;

    localparam carry_t CARRY_INIT = '{
        hit:       1'b0,
        hit_idx:   '0,
        frame:     '0,
        empty:     1'b0,
        empty_idx: '0,
        min_age:   '1,
        min_idx:   '0
    };

    // entry update broadcast to all cells
    typedef struct packed {
        logic                  wr_entry;
        logic                  wr_age;
        logic [IDX_BITS-1:0]   idx;
        logic [PID_BITS-1:0]   owner;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic [AGE_BITS-1:0]   age;
    } upd_t;

endpackage

`default_nettype wire

[hw/rtl/tlbr_cell.sv]
// ----------------------------------------------------------------------------
// tlbr_cell
// One buffer entry: stores owner, page, frame and age stamp, folds its entry
// into the search carry and registers the carry for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbr_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [tlbr_pkg::IDX_BITS-1:0]  cell_idx,
    input  wire logic                           active,
    input  wire tlbr_pkg::key_t                 key,
    input  wire tlbr_pkg::carry_t               carry_in,
    input  wire tlbr_pkg::upd_t                 upd,
    output tlbr_pkg::carry_t                    carry_out
);

    import tlbr_pkg::*;

    logic [PID_BITS-1:0]   owner_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [AGE_BITS-1:0]   age_reg;
    carry_t                carry_reg;
    carry_t                carry_next;
    logic                  sel;

    assign sel = (upd.idx == cell_idx);

    always_comb
    begin
        carry_next = carry_in;
        if (active)
        begin
            if (!carry_in.hit && key.pid != '0 && owner_reg == key.pid
                && page_reg == key.page)
            begin
                carry_next.hit     = 1'b1;
                carry_next.hit_idx = cell_idx;
                carry_next.frame   = frame_reg;
            end
            if (!carry_in.empty && owner_reg == '0)
            begin
                carry_next.empty     = 1'b1;
                carry_next.empty_idx = cell_idx;
            end
            // strict less keeps the earlier cell on equal stamps
            if (age_reg < carry_in.min_age)
            begin
                carry_next.min_age = age_reg;
                carry_next.min_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            page_reg  <= '0;
            frame_reg <= '0;
            age_reg   <= '0;
        end
        else if (upd.wr_entry && sel)
        begin
            owner_reg <= upd.owner;
            page_reg  <= upd.page;
            frame_reg <= upd.frame;
            age_reg   <= upd.age;
        end
        else if (upd.wr_age && sel)
        begin
            age_reg <= upd.age;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

[hw/rtl/tlbr_regs.sv]
// ----------------------------------------------------------------------------
// tlbr_regs
// APB register file: active entry count and replacement mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbr_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tlbr_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [tlbr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [tlbr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready,
    output logic [tlbr_pkg::USE_BITS-1:0]        entries_in_use,
    output logic                                 replace_mode
);

    import tlbr_pkg::*;

    logic [USE_BITS-1:0] use_reg;
    logic                mode_reg;
    logic                wr_en;
    logic                reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg  <= USE_RESET;
            mode_reg <= MODE_FIFO;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENTRIES: use_reg  <= pwdata[USE_BITS-1:0];
                REG_MODE:    mode_reg <= pwdata[0];
                default:     use_reg  <= use_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ENTRIES: prdata = DATA_BITS'(use_reg);
            REG_MODE:    prdata = DATA_BITS'(mode_reg);
            default:     prdata = '0;
        endcase
    end

    assign entries_in_use = use_reg;
    assign replace_mode   = mode_reg;

endmodule

`default_nettype wire

[hw/rtl/tlb_fifo_lru_replace.sv]
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replace
// Fully associative translation buffer with FIFO or LRU victim choice.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The key then walks the
// row of entry cells one cell per clock, and busy stays high until the walk
// ends; done strobes the result for one cycle right after, and a new start can
// be taken in that same cycle, so a new item waits until the last is through.
// Results cannot be held off.
`default_nettype none

module tlb_fifo_lru_replace (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tlbr_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [tlbr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [tlbr_pkg::DATA_BITS-1:0]        prdata,
    output logic                                  pready,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             operation,
    input  wire logic [tlbr_pkg::PID_BITS-1:0]    proc_id,
    input  wire logic [tlbr_pkg::PAGE_BITS-1:0]   page_num,
    input  wire logic [tlbr_pkg::FRAME_BITS-1:0]  frame_in,
    output logic                                  done,
    output logic                                  hit,
    output logic [tlbr_pkg::FRAME_BITS-1:0]       frame_out,
    output logic [tlbr_pkg::SLOT_BITS-1:0]        slot,
    output logic                                  evicted
);

    import tlbr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [USE_BITS-1:0]   entries_in_use;
    logic                  replace_mode;

    logic                  state_reg;
    logic                  state_next;
    logic [SCAN_BITS-1:0]  cnt_reg;
    logic [SCAN_BITS-1:0]  cnt_next;
    key_t                  key_reg;
    logic                  op_reg;
    logic [FRAME_BITS-1:0] frame_in_reg;
    logic [IDX_BITS-1:0]   fifo_ptr_reg;
    logic [IDX_BITS-1:0]   fifo_ptr_next;
    logic [AGE_BITS-1:0]   clock_reg;
    logic [AGE_BITS-1:0]   clock_next;

    logic                  done_reg;
    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_out_reg;
    logic [IDX_BITS-1:0]   slot_reg;
    logic                  evicted_reg;
    logic                  hit_next;
    logic [FRAME_BITS-1:0] frame_out_next;
    logic [IDX_BITS-1:0]   slot_next;
    logic                  evicted_next;

    logic [ACT_BITS-1:0]   act_n;
    logic                  accept;
    logic                  commit;
    logic [IDX_BITS-1:0]   fifo_v;
    carry_t                fin;
    upd_t                  upd;
    carry_t                chain [TLB_DEPTH+1];

    tlbr_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .entries_in_use (entries_in_use),
        .replace_mode   (replace_mode)
    );

    assign act_n = (ACT_BITS'(entries_in_use) > ACT_BITS'(TLB_DEPTH))
                 ? ACT_BITS'(TLB_DEPTH) : ACT_BITS'(entries_in_use);

    assign chain[0] = CARRY_INIT;

    for (genvar gi = 0; gi < TLB_DEPTH; gi++)
    begin : g_cell
        tlbr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_BITS'(gi)),
            .active    (ACT_BITS'(gi) < act_n),
            .key       (key_reg),
            .carry_in  (chain[gi]),
            .upd       (upd),
            .carry_out (chain[gi+1])
        );
    end

    assign fin    = chain[TLB_DEPTH];
    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign commit = (state_reg == ST_SCAN) && (cnt_reg == SCAN_BITS'(TLB_DEPTH));

    // stale pointer falls back to entry zero
    assign fifo_v = (ACT_BITS'(fifo_ptr_reg) < act_n) ? fifo_ptr_reg : '0;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fifo_ptr_next  = fifo_ptr_reg;
        clock_next     = clock_reg;
        hit_next       = 1'b0;
        frame_out_next = '0;
        slot_next      = '0;
        evicted_next   = 1'b0;
        upd            = '0;
        upd.owner      = key_reg.pid;
        upd.page       = key_reg.page;
        upd.frame      = frame_in_reg;
        upd.age        = clock_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                    if (act_n != '0)
                    begin
                        if (op_reg == OP_LOOKUP)
                        begin
                            if (fin.hit)
                            begin
                                upd.wr_age     = 1'b1;
                                upd.idx        = fin.hit_idx;
                                hit_next       = 1'b1;
                                frame_out_next = fin.frame;
                                slot_next      = fin.hit_idx;
                            end
                        end
                        else
                        begin
                            upd.wr_entry = 1'b1;
                            if (fin.empty)
                            begin
                                upd.idx = fin.empty_idx;
                            end
                            else if (replace_mode == MODE_LRU)
                            begin
                                upd.idx      = fin.min_idx;
                                evicted_next = 1'b1;
                            end
                            else
                            begin
                                upd.idx       = fifo_v;
                                evicted_next  = 1'b1;
                                fifo_ptr_next = (ACT_BITS'(fifo_v) + ACT_BITS'(1) == act_n)
                                              ? '0 : fifo_v + IDX_BITS'(1);
                            end
                            slot_next = upd.idx;
                        end
                        // saturating access counter stands in for the time stamp
                        if ((upd.wr_entry || upd.wr_age) && clock_reg != '1)
                        begin
                            clock_next = clock_reg + AGE_BITS'(1);
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + SCAN_BITS'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            fifo_ptr_reg <= '0;
            clock_reg    <= CLOCK_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fifo_ptr_reg <= fifo_ptr_next;
            clock_reg    <= clock_next;
            done_reg     <= commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.pid  <= proc_id;
            key_reg.page <= page_num;
            op_reg       <= operation;
            frame_in_reg <= frame_in;
        end
        if (commit)
        begin
            hit_reg       <= hit_next;
            frame_out_reg <= frame_out_next;
            slot_reg      <= slot_next;
            evicted_reg   <= evicted_next;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign frame_out = frame_out_reg;
    assign slot      = SLOT_BITS'(slot_reg);
    assign evicted   = evicted_reg;

`ifndef SYNTHESIS
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN))
        else $error("result strobe without a finished scan");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a new scan is running");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cnt_reg <= SCAN_BITS'(TLB_DEPTH))
        else $error("scan counter ran past the cell row");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> clock_reg >= $past(clock_reg) && clock_reg != '0)
        else $error("access counter went back or wrapped");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !evicted)
        else $error("lookup hit flagged an eviction");
`endif

endmodule

`default_nettype wire
